// ===== rtl/core/tpiq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpiq_pkg
// Shared types and constants for the three-point insertion queue.
// ----------------------------------------------------------------------------
package tpiq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OUT_CNT_W = 5;

  // slave tdata: value, priority_req, zero fill to whole bytes
  localparam int IN_BITS   = VALUE_W + PRIO_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // master tdata: head_value, entry_count, is_full, is_empty, zero fill
  localparam int OUT_BITS   = VALUE_W + OUT_CNT_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int OUT_CNT_LSB  = VALUE_W;
  localparam int OUT_FULL_BIT = VALUE_W + OUT_CNT_W;
  localparam int OUT_EMPTY_BIT = OUT_FULL_BIT + 1;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [PRIO_W-1:0] {
    PRIO_HIGH = 2'd0,
    PRIO_MID  = 2'd1,
    PRIO_LOW  = 2'd2
  } prio_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

// ===== rtl/core/three_point_insertion_queue.sv =====
// ----------------------------------------------------------------------------
// three_point_insertion_queue
// Bounded ordered queue in a shift array with head, middle and tail insertion.
// ----------------------------------------------------------------------------
// path: input register, then result register, then the master side
// throughput: one transaction per cycle while results are taken, set by the parallel
//   shift of all slots between the input register and the result register
// reset: clears the entry count and both valid flags, the queue starts empty;
//   slot contents are not reset and are only read once written
module three_point_insertion_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [tpiq_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // value, priority_req
  input  logic                              s_axis_tuser_i,  // cmd
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [tpiq_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,  // head_value, entry_count,
                                                             // is_full, is_empty
  output logic [tpiq_pkg::STATUS_W-1:0]     m_axis_tuser_o   // status
);
  import tpiq_pkg::*;

  // input register
  logic                       in_valid_q;
  logic                       cmd_q;
  logic signed [VALUE_W-1:0]  value_q;
  logic [PRIO_W-1:0]          prio_q;

  // queue state
  logic signed [VALUE_W-1:0]  slots_q [CAPACITY];
  logic signed [VALUE_W-1:0]  slots_d [CAPACITY];
  logic [CNT_W-1:0]           occ_q;
  logic [CNT_W-1:0]           occ_d;

  // result register
  logic                       out_valid_q;
  logic [STATUS_W-1:0]        status_q;
  logic [STATUS_W-1:0]        status_d;
  logic signed [VALUE_W-1:0]  head_q;
  logic signed [VALUE_W-1:0]  head_d;
  logic [OUT_CNT_W-1:0]       count_q;
  logic                       full_q;
  logic                       empty_q;

  logic                       advance;
  logic                       is_enq;
  logic                       q_full;
  logic                       q_empty;
  logic                       do_enq;
  logic                       do_deq;
  logic [CNT_W-1:0]           pos;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      occ_q       <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        occ_q       <= occ_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q   <= s_axis_tuser_i;
      value_q <= s_axis_tdata_i[VALUE_W-1:0];
      prio_q  <= s_axis_tdata_i[VALUE_W +: PRIO_W];
    end
    if (advance) begin
      slots_q  <= slots_d;
      status_q <= status_d;
      head_q   <= head_d;
      count_q  <= OUT_CNT_W'(occ_d);
      full_q   <= (occ_d == CNT_W'(CAPACITY));
      empty_q  <= (occ_d == '0);
    end
  end

  assign is_enq  = (cmd_q == CMD_ENQ);
  assign q_full  = (occ_q >= CNT_W'(CAPACITY));
  assign q_empty = (occ_q == '0);
  assign do_enq  = is_enq && !q_full;
  assign do_deq  = !is_enq && !q_empty;

  // insertion point, the unused code goes to the tail
  always_comb begin
    unique case (prio_q)
      PRIO_HIGH: pos = '0;
      PRIO_MID:  pos = occ_q >> 1;
      default:   pos = occ_q;
    endcase
  end

  // every slot picks its own next value in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slots_d[i] = slots_q[i];
    end
    if (do_enq) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (CNT_W'(i) > pos && CNT_W'(i) <= occ_q) begin
          slots_d[i] = slots_q[i-1];
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (CNT_W'(i) == pos) begin
          slots_d[i] = value_q;
        end
      end
    end
    if (do_deq) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (CNT_W'(i + 1) < occ_q) begin
          slots_d[i] = slots_q[i+1];
        end
      end
    end
  end

  always_comb begin
    occ_d    = occ_q;
    head_d   = '0;
    status_d = STATUS_DONE;
    if (is_enq) begin
      if (q_full) begin
        status_d = STATUS_FULL;
      end else begin
        occ_d = occ_q + CNT_W'(1);
      end
    end else begin
      if (q_empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        occ_d  = occ_q - CNT_W'(1);
        head_d = slots_q[0];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - OUT_BITS)'(0), empty_q, full_q, count_q, head_q};

endmodule

// ===== rtl/core/tpiq_checker.sv =====
// ----------------------------------------------------------------------------
// tpiq_checker
// Port-level checks for the three-point insertion queue, bound to the top.
// ----------------------------------------------------------------------------
module tpiq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [tpiq_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  input logic [tpiq_pkg::STATUS_W-1:0]     m_axis_tuser_o
);
  import tpiq_pkg::*;

  logic full_flag;
  logic empty_flag;
  logic [OUT_CNT_W-1:0] cnt;

  assign full_flag  = m_axis_tdata_o[OUT_FULL_BIT];
  assign empty_flag = m_axis_tdata_o[OUT_EMPTY_BIT];
  assign cnt        = m_axis_tdata_o[OUT_CNT_LSB +: OUT_CNT_W];

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // input back-pressure only while a result is held by the receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a held result");

  // a rejected enqueue only happens on a full queue, reported as such
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_FULL |->
      full_flag && m_axis_tdata_o[VALUE_W-1:0] == '0)
    else $error("full rejection without full flag");

  // a rejected dequeue only happens on an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_EMPTY |->
      empty_flag && cnt == '0 && m_axis_tdata_o[VALUE_W-1:0] == '0)
    else $error("empty rejection on a non-empty queue");

  // flags agree with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(full_flag && empty_flag) && (empty_flag == (cnt == '0)))
    else $error("flags disagree with entry count");

endmodule

bind three_point_insertion_queue tpiq_checker u_tpiq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
